/* hw/rtl/ist_pkg.sv */
// Package for the integer set table: shared widths, sentinels, operation codes,
// sequencer states and the control bundle passed from the sequencer to the datapath.
// No dependencies.
`default_nettype none

package ist_pkg;

  // Element width and default table size.
  localparam int ElemW      = 32;
  localparam int CapacityDef = 64;

  // Minimum and maximum reported for an empty set.
  localparam logic signed [ElemW-1:0] SentMax = 32'sh7FFF_FFFF;
  localparam logic signed [ElemW-1:0] SentMin = 32'sh8000_0000;

  // Operation codes carried in the operation field.
  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_MEMBER = 2'd2,
    OP_CLEAR  = 2'd3
  } op_e;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_e;

  // Strobes from the sequencer to the datapath.
  typedef struct packed {
    logic start;     // input transaction taken this cycle
    logic data_vld;  // table read data is valid this cycle
    logic commit;    // result is loaded and state updated this cycle
  } ctrl_t;

endpackage

`default_nettype wire

/* hw/rtl/integer_set_table.sv */
// Integer set table: a set of distinct signed 32-bit integers kept in a RAM table
// with an element count. Top level; depends on ist_pkg, ist_ram and ist_ctrl.
//
// Usage:
//   The input channel (in_valid_i / in_ready_o) carries one operation and a value
//   per transaction: insert, remove, member test or clear. The output channel
//   (out_valid_o / out_ready_i) returns exactly one result per input transaction:
//   found, accepted, the element count and the minimum and maximum afterwards.
//   An empty set reports 0x7FFFFFFF as minimum and 0x80000000 as maximum.
//   Each operation except clear reads every stored entry once through the single
//   RAM read port, matching, compacting on remove and tracking the extremes on
//   the way. An item passes from acceptance through the scan state to the finish
//   state, where its result is loaded; a clear skips the scan. A new transaction
//   is accepted the cycle after the previous result is loaded, so the table takes
//   no new item before the result of the previous one has been loaded.
//   The result sits in an output register; a stalled receiver delays only the
//   load of the next result, and the following item is still accepted and
//   scanned meanwhile. Reset empties the set; the RAM contents need no clearing.
`default_nettype none

module integer_set_table #(
  parameter int CAPACITY = ist_pkg::CapacityDef
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [1:0]         operation_i,
  input  wire logic signed [31:0] value_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic                    found_o,
  output logic                    accepted_o,
  output logic [6:0]              element_count_o,
  output logic signed [31:0]      minimum_o,
  output logic signed [31:0]      maximum_o
);

  localparam int CntW  = $clog2(CAPACITY + 1);
  localparam int AddrW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam logic [CntW-1:0] CapC = CntW'(CAPACITY);

  ist_pkg::ctrl_t ctrl;
  logic              rd_en;
  logic [AddrW-1:0]  rd_addr;
  logic [AddrW-1:0]  data_idx;
  logic [ist_pkg::ElemW-1:0] rdata;
  logic              out_free;

  // Item under work.
  logic [1:0]               op_q;
  logic signed [31:0]       value_q;
  logic                     found_q, found_d;
  logic signed [31:0]       lo_q, lo_d, hi_q, hi_d;
  logic [CntW-1:0]          count_q, count_d;

  // Output register.
  logic                     out_valid_q, out_valid_d;
  logic                     out_found_q;
  logic                     out_acc_q;
  logic [6:0]               out_count_q;
  logic signed [31:0]       out_min_q, out_max_q;

  // RAM write port.
  logic                     we;
  logic [AddrW-1:0]         waddr;
  logic [ist_pkg::ElemW-1:0] wdata;

  logic signed [31:0]       elem;
  logic                     match;
  logic                     is_remove;
  logic                     is_insert;
  logic                     ins_new;
  logic                     ins_full;
  logic                     shift_wr;
  logic signed [31:0]       res_min, res_max;

  assign out_free = !out_valid_q || out_ready_i;

  ist_ctrl #(
    .CAPACITY (CAPACITY),
    .CNT_W    (CntW),
    .ADDR_W   (AddrW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .operation_i (operation_i),
    .count_i     (count_q),
    .out_free_i  (out_free),
    .in_ready_o  (in_ready_o),
    .rd_en_o     (rd_en),
    .rd_addr_o   (rd_addr),
    .data_idx_o  (data_idx),
    .ctrl_o      (ctrl)
  );

  ist_ram #(
    .WIDTH  (ist_pkg::ElemW),
    .DEPTH  (CAPACITY),
    .ADDR_W (AddrW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rdata)
  );

  assign elem      = rdata;
  assign match     = (elem == value_q);
  assign is_remove = (op_q == ist_pkg::OP_REMOVE);
  assign is_insert = (op_q == ist_pkg::OP_INSERT);
  assign ins_new   = is_insert && !found_q && (count_q != CapC);
  assign ins_full  = is_insert && !found_q && (count_q == CapC);

  // On remove, every entry after the match moves down by one place.
  assign shift_wr = ctrl.data_vld && is_remove && found_q;

  // RAM write: compaction during the scan, append at commit.
  always_comb begin
    we    = 1'b0;
    waddr = data_idx - AddrW'(1);
    wdata = elem;
    if (shift_wr) begin
      we = 1'b1;
    end else if (ctrl.commit && ins_new) begin
      we    = 1'b1;
      waddr = count_q[AddrW-1:0];
      wdata = value_q;
    end
  end

  // Scan accumulation: match flag and running extremes. The removed entry is
  // left out of the extremes.
  always_comb begin
    found_d = found_q;
    lo_d    = lo_q;
    hi_d    = hi_q;
    if (ctrl.start) begin
      found_d = 1'b0;
      lo_d    = ist_pkg::SentMax;
      hi_d    = ist_pkg::SentMin;
    end else if (ctrl.data_vld) begin
      if (match) begin
        found_d = 1'b1;
      end
      if (!(match && is_remove)) begin
        if (elem < lo_q) begin
          lo_d = elem;
        end
        if (elem > hi_q) begin
          hi_d = elem;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.start) begin
      op_q    <= operation_i;
      value_q <= value_i;
    end
    found_q <= found_d;
    lo_q    <= lo_d;
    hi_q    <= hi_d;
  end

  // Result: a newly inserted value joins the extremes.
  always_comb begin
    res_min = lo_q;
    res_max = hi_q;
    if (ins_new) begin
      if (value_q < lo_q) begin
        res_min = value_q;
      end
      if (value_q > hi_q) begin
        res_max = value_q;
      end
    end
  end

  // Element count after the operation.
  always_comb begin
    count_d = count_q;
    if (ctrl.commit) begin
      case (op_q)
        ist_pkg::OP_CLEAR:  count_d = '0;
        ist_pkg::OP_INSERT: count_d = ins_new ? count_q + CntW'(1) : count_q;
        ist_pkg::OP_REMOVE: count_d = found_q ? count_q - CntW'(1) : count_q;
        ist_pkg::OP_MEMBER: count_d = count_q;
        default:            count_d = count_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  // Output register: loads on commit, empties when the transaction completes.
  always_comb begin
    out_valid_d = out_valid_q;
    if (ctrl.commit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.commit) begin
      out_found_q <= found_q && (op_q != ist_pkg::OP_CLEAR);
      out_acc_q   <= !ins_full;
      out_count_q <= 7'(count_d);
      out_min_q   <= res_min;
      out_max_q   <= res_max;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign found_o         = out_found_q;
  assign accepted_o      = out_acc_q;
  assign element_count_o = out_count_q;
  assign minimum_o       = out_min_q;
  assign maximum_o       = out_max_q;

endmodule

`default_nettype wire

/* hw/rtl/ist_ram.sv */
// Generic single-write, single-read synchronous RAM with a registered read port.
// No dependencies.
`default_nettype none

module ist_ram #(
  parameter int WIDTH  = 32,
  parameter int DEPTH  = 64,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]  wdata_i,
  input  wire logic              re_i,
  input  wire logic [ADDR_W-1:0] raddr_i,
  output logic      [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* hw/rtl/ist_ctrl.sv */
// Sequencer for the integer set table: walks the stored entries through the RAM read
// port and tells the datapath when read data is valid and when to commit a result.
// Depends on ist_pkg.
`default_nettype none

module ist_ctrl #(
  parameter int CAPACITY = ist_pkg::CapacityDef,
  parameter int CNT_W    = $clog2(CAPACITY + 1),
  parameter int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  input  wire logic [1:0]        operation_i,
  input  wire logic [CNT_W-1:0]  count_i,
  input  wire logic              out_free_i,
  output logic                   in_ready_o,
  output logic                   rd_en_o,
  output logic [ADDR_W-1:0]      rd_addr_o,
  output logic [ADDR_W-1:0]      data_idx_o,
  output ist_pkg::ctrl_t         ctrl_o
);

  ist_pkg::state_e   state_q, state_d;
  logic [CNT_W-1:0]  rd_idx_q, rd_idx_d;
  logic              data_vld_q;
  logic [ADDR_W-1:0] data_idx_q;
  logic              issue;

  // A read is issued while unread entries remain in the scan.
  assign issue     = (state_q == ist_pkg::ST_SCAN) && (rd_idx_q < count_i);
  assign rd_addr_o = rd_idx_q[ADDR_W-1:0];

  // Next-state logic. A clear needs no scan.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ist_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = (operation_i == ist_pkg::OP_CLEAR) ? ist_pkg::ST_FINISH
                                                        : ist_pkg::ST_SCAN;
        end
      end
      ist_pkg::ST_SCAN: begin
        if (!issue && !data_vld_q) begin
          state_d = ist_pkg::ST_FINISH;
        end
      end
      ist_pkg::ST_FINISH: begin
        if (out_free_i) begin
          state_d = ist_pkg::ST_IDLE;
        end
      end
      default: state_d = ist_pkg::ST_IDLE;
    endcase
  end

  // Output logic.
  always_comb begin
    in_ready_o      = 1'b0;
    ctrl_o.start    = 1'b0;
    ctrl_o.data_vld = data_vld_q;
    ctrl_o.commit   = 1'b0;
    rd_en_o         = issue;
    case (state_q)
      ist_pkg::ST_IDLE: begin
        in_ready_o   = 1'b1;
        ctrl_o.start = in_valid_i;
      end
      ist_pkg::ST_SCAN: begin
      end
      ist_pkg::ST_FINISH: begin
        ctrl_o.commit = out_free_i;
      end
      default: begin
      end
    endcase
  end

  // Read index restarts for every item and advances with each issued read.
  always_comb begin
    rd_idx_d = rd_idx_q;
    if (state_q == ist_pkg::ST_IDLE) begin
      rd_idx_d = '0;
    end else if (issue) begin
      rd_idx_d = rd_idx_q + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ist_pkg::ST_IDLE;
      rd_idx_q   <= '0;
      data_vld_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      rd_idx_q   <= rd_idx_d;
      data_vld_q <= issue;
    end
  end

  // Index of the entry whose read data is on the RAM output, registered with the read.
  always_ff @(posedge clk_i) begin
    if (issue) begin
      data_idx_q <= rd_addr_o;
    end
  end

  assign data_idx_o = data_idx_q;

endmodule

`default_nettype wire
